@@ hdl/sync_framed_xor_packet_parser_unit_defines.svh @@
// Assertion macros for the framed packet parser.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef SYNC_FRAMED_XOR_PACKET_PARSER_UNIT_DEFINES_SVH
`define SYNC_FRAMED_XOR_PACKET_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SFXP_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFXP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sfxp_pkg.sv @@
// Shared types and constants of the framed packet parser.
// No dependencies.
package sfxp_pkg;

    localparam int unsigned FRAME_LEN  = 20;
    localparam int unsigned CELL_COUNT = FRAME_LEN - 3;   // body bytes 2..18
    localparam int unsigned WORD_COUNT = 8;
    localparam int unsigned CENTRE_IDX = 6;
    localparam logic [15:0] CENTRE_RESET = 16'd2048;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;
    localparam logic [1:0] FLAG_MASK   = 2'b11;   // manual active, tracking

    // Parse positions
    localparam logic [4:0] POS_HUNT  = 5'd0;
    localparam logic [4:0] POS_SYNC2 = 5'd1;
    localparam logic [4:0] POS_BODY  = 5'd2;
    localparam logic [4:0] POS_LAST  = 5'(FRAME_LEN - 1);

    // Controller to datapath
    typedef struct packed {
        logic shift;     // body byte enters the cell chain
        logic done;      // check byte taken, frame complete
        logic ok;        // XOR matched the check byte
        logic at_last;   // next byte is the check byte
    } t_ctrl;

    typedef struct packed {
        logic               frame_ok;
        logic [1:0]         mode_flags;
        logic signed [15:0] manual_speed;
        logic signed [15:0] error_norm;
        logic signed [15:0] error_rate;
        logic signed [15:0] prop_gain;
        logic signed [15:0] speed_ceiling;
        logic signed [15:0] deriv_time;
        logic [15:0]        pot_center_value;
        logic signed [15:0] velocity_gain;
        logic [31:0]        good_frames;
        logic [31:0]        bad_frames;
    } t_result;

endpackage

@@ hdl/sfxp_ifs.sv @@
// Handshake channels of the framed packet parser: received bytes and results.
// Depends on sfxp_pkg.
interface sfxp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfxp_res_if;
    logic              valid;
    logic              ready;
    sfxp_pkg::t_result item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

@@ hdl/sfxp_cell.sv @@
// One byte cell of the body shift chain.
// No dependencies.
module sfxp_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    output logic [7:0] o_byte
);
    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // Take the neighbor's byte on a shift, else hold
    assign n_byte = i_shift ? i_byte : r_byte;

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;
endmodule

@@ hdl/sfxp_ctrl.sv @@
// Preamble hunt, frame position and running XOR of the parser.
// Depends on sfxp_pkg.
module sfxp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    output sfxp_pkg::t_ctrl o_ctrl
);
    import sfxp_pkg::*;

    logic [4:0] r_pos;
    logic [4:0] n_pos;
    logic [7:0] r_xor;
    logic [7:0] n_xor;
    logic       w_shift;
    logic       w_done;

    // Next position and checksum for the accepted byte
    always_comb begin
        n_pos   = r_pos;
        n_xor   = r_xor;
        w_shift = 1'b0;
        w_done  = 1'b0;
        if (i_accept) begin
            if (r_pos == POS_HUNT || r_pos > POS_LAST) begin
                n_pos = (i_byte == SYNC_FIRST) ? POS_SYNC2 : POS_HUNT;
            end else if (r_pos == POS_SYNC2) begin
                if (i_byte == SYNC_SECOND) begin
                    n_pos = POS_BODY;
                    n_xor = SYNC_FIRST ^ SYNC_SECOND;
                end else if (i_byte != SYNC_FIRST) begin
                    n_pos = POS_HUNT;
                end
            end else if (r_pos == POS_LAST) begin
                w_done = 1'b1;
                n_pos  = POS_HUNT;
            end else begin
                w_shift = 1'b1;
                n_xor   = r_xor ^ i_byte;
                n_pos   = r_pos + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
        end else begin
            r_pos <= n_pos;
        end
        r_xor <= n_xor;
    end

    assign o_ctrl.shift   = w_shift;
    assign o_ctrl.done    = w_done;
    assign o_ctrl.ok      = (r_xor == i_byte);
    assign o_ctrl.at_last = (r_pos == POS_LAST);
endmodule

@@ hdl/sync_framed_xor_packet_parser_unit.sv @@
// Channel   Dir  Payload                          Moves
// i_rx      in   rx_byte[7:0]                     one received byte per item
// o_res     out  t_result (check flag, held, cnt)  one result per completed frame
//
// Takes one byte per cycle; body bytes are folded into a running XOR that is
// compared with the check byte as it is taken, and the frame's result is
// registered at that same edge, visible on o_res from the next cycle.
// Body bytes 2..18 travel through a chain of 17 byte cells; the check reads
// them in place. Reset is synchronous, active low, and clears position, held
// values (centre word 2048) and counters. Input stalls only when a result
// waits on o_res and the next byte would complete another frame.
// Depends on sfxp_pkg, sfxp_ifs, sfxp_ctrl, sfxp_cell and the defines header.
`include "sync_framed_xor_packet_parser_unit_defines.svh"

module sync_framed_xor_packet_parser_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sfxp_rx_if.sink         i_rx,
    sfxp_res_if.source      o_res
);
    import sfxp_pkg::*;

    t_ctrl       w_ctrl;
    logic        w_accept;
    logic [7:0]  w_chain [CELL_COUNT+1];

    logic [1:0]  r_flags;
    logic [1:0]  n_flags;
    logic [15:0] r_words [WORD_COUNT];
    logic [15:0] n_words [WORD_COUNT];
    logic [31:0] r_good;
    logic [31:0] n_good;
    logic [31:0] r_bad;
    logic [31:0] n_bad;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;

    // Hold input only if a finished result is stuck and another would follow
    assign i_rx.ready = !r_out_valid || o_res.ready || !w_ctrl.at_last;
    assign w_accept   = i_rx.valid && i_rx.ready;

    sfxp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_rx.rx_byte),
        .o_ctrl   (w_ctrl)
    );

    // Body byte chain: cell k holds frame byte 18-k at the check
    assign w_chain[0] = i_rx.rx_byte;
    for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
        sfxp_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_ctrl.shift),
            .i_byte  (w_chain[k]),
            .o_byte  (w_chain[k+1])
        );
    end

    // Held values and counters after the frame check
    always_comb begin
        n_flags = r_flags;
        n_good  = r_good;
        n_bad   = r_bad;
        for (int i = 0; i < WORD_COUNT; i++) begin
            n_words[i] = r_words[i];
        end
        if (w_ctrl.done) begin
            if (w_ctrl.ok) begin
                n_flags = w_chain[CELL_COUNT][1:0] & FLAG_MASK;
                for (int i = 0; i < WORD_COUNT; i++) begin
                    n_words[i] = {w_chain[15 - 2*i], w_chain[16 - 2*i]};
                end
                n_good = r_good + 32'd1;
            end else begin
                n_bad = r_bad + 32'd1;
            end
        end
    end

    // Result fields
    always_comb begin
        n_out.frame_ok         = w_ctrl.ok;
        n_out.mode_flags       = n_flags;
        n_out.manual_speed     = n_words[0];
        n_out.error_norm       = n_words[1];
        n_out.error_rate       = n_words[2];
        n_out.prop_gain        = n_words[3];
        n_out.speed_ceiling    = n_words[4];
        n_out.deriv_time       = n_words[5];
        n_out.pot_center_value = n_words[6];
        n_out.velocity_gain    = n_words[7];
        n_out.good_frames      = n_good;
        n_out.bad_frames       = n_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            for (int i = 0; i < WORD_COUNT; i++) begin
                r_words[i] <= (i == CENTRE_IDX) ? CENTRE_RESET : 16'd0;
            end
            r_good      <= '0;
            r_bad       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_flags <= n_flags;
            for (int i = 0; i < WORD_COUNT; i++) begin
                r_words[i] <= n_words[i];
            end
            r_good <= n_good;
            r_bad  <= n_bad;
            if (w_ctrl.done) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_ctrl.done) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.item  = r_out;

    // Checks
    `SFXP_ASSERT_NOW(a_no_overrun, r_out_valid && !o_res.ready && w_ctrl.at_last, !i_rx.ready, "byte taken over a waiting result")
    `SFXP_ASSERT_NEXT(a_done_gives_result, w_ctrl.done, r_out_valid, "completed frame gave no result")
    `SFXP_ASSERT_NEXT(a_counts_only_on_done, i_rst_n && !w_ctrl.done, $stable(r_good) && $stable(r_bad), "counter moved without a frame")
    `SFXP_ASSERT_NOW(a_done_at_last, w_ctrl.done, w_ctrl.at_last && w_accept, "frame ended off the check byte")
endmodule

@@ sim/sync_framed_xor_packet_parser_unit_tb.sv @@
// Self-checking testbench for the framed XOR packet parser: byte stimulus in,
// per-frame results checked against a running model of the parser.
// Depends on sfxp_pkg, sfxp_ifs and sync_framed_xor_packet_parser_unit.
`timescale 1ns / 1ps

module sync_framed_xor_packet_parser_unit_tb;
    import sfxp_pkg::*;

    localparam int RANDOM_BYTES   = 1500;
    localparam int DIRECTED_ROWS  = 24;
    localparam int HOLD_CYCLES    = 150;   // long receiver hold-off
    localparam int DRAIN_LIMIT    = 20000;
    localparam int SETTLE_CYCLES  = 16;    // result lands in the cycle after its check byte
    localparam int REPORT_LIMIT   = 10;
    localparam int IDLE_PERCENT   = 22;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       hand_checked;   // expected result typed in below
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sfxp_rx_if  rx_if ();
    sfxp_res_if res_if ();

    sync_framed_xor_packet_parser_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Generous cap on the whole run
    initial begin
        #2_000_000;
        $display("sync_framed_xor_packet_parser_unit_tb: errors");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Parser model: position, captured frame, held values, counters
    // ---------------------------------------------------------------------
    logic [4:0]  parse_pos;
    logic [7:0]  frame_bytes [FRAME_LEN];
    logic [1:0]  held_flags;
    logic [15:0] held_words [WORD_COUNT];
    logic [31:0] good_total;
    logic [31:0] bad_total;

    t_result expected_frames [$];

    int sent_bytes;
    int mismatch_count = 0;
    int frames_checked = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    t_result oldest_frame;
    t_result all_ones_frame;

    task automatic clear_parser_model();
        int i;
        parse_pos = POS_HUNT;
        held_flags = 2'b00;
        for (i = 0; i < WORD_COUNT; i++)
            held_words[i] = 16'h0000;
        held_words[CENTRE_IDX] = CENTRE_RESET;
        good_total = 32'd0;
        bad_total = 32'd0;
    endtask

    // Advance the model by one byte; returns 1 when the byte closes a frame
    function automatic bit parse_byte(input logic [7:0] b, output t_result frame_res);
        int         i;
        logic [7:0] running_xor;
        bit         frame_done;
        frame_res = '0;
        frame_done = 1'b0;
        if (parse_pos == POS_HUNT || parse_pos > POS_LAST) begin
            parse_pos = POS_HUNT;
            if (b == SYNC_FIRST) begin
                frame_bytes[0] = b;
                parse_pos = POS_SYNC2;
            end
        end else if (parse_pos == POS_SYNC2) begin
            // repeated first sync byte keeps waiting, anything else restarts
            if (b == SYNC_SECOND) begin
                frame_bytes[1] = b;
                parse_pos = POS_BODY;
            end else if (b != SYNC_FIRST) begin
                parse_pos = POS_HUNT;
            end
        end else begin
            frame_bytes[parse_pos] = b;
            if (parse_pos == POS_LAST) begin
                parse_pos = POS_HUNT;
                frame_done = 1'b1;
                running_xor = 8'h00;
                for (i = 0; i < FRAME_LEN - 1; i++)
                    running_xor ^= frame_bytes[i];
                frame_res.frame_ok = (running_xor == frame_bytes[FRAME_LEN - 1]);
                if (frame_res.frame_ok) begin
                    held_flags = frame_bytes[2][1:0] & FLAG_MASK;
                    for (i = 0; i < WORD_COUNT; i++)
                        held_words[i] = {frame_bytes[4 + 2 * i], frame_bytes[3 + 2 * i]};
                    good_total = good_total + 32'd1;
                end else begin
                    bad_total = bad_total + 32'd1;
                end
                frame_res.mode_flags       = held_flags;
                frame_res.manual_speed     = held_words[0];
                frame_res.error_norm       = held_words[1];
                frame_res.error_rate       = held_words[2];
                frame_res.prop_gain        = held_words[3];
                frame_res.speed_ceiling    = held_words[4];
                frame_res.deriv_time       = held_words[5];
                frame_res.pot_center_value = held_words[6];
                frame_res.velocity_gain    = held_words[7];
                frame_res.good_frames      = good_total;
                frame_res.bad_frames       = bad_total;
            end else begin
                parse_pos = parse_pos + 5'd1;
            end
        end
        return frame_done;
    endfunction

    // ---------------------------------------------------------------------
    // Byte sender
    // ---------------------------------------------------------------------
    function automatic bit sender_pauses();
        // no gaps at all through the middle of the random bytes
        if (sent_bytes >= 700 && sent_bytes < 1000)
            return 1'b0;
        return $urandom_range(99) < IDLE_PERCENT;
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit use_hand = 1'b0,
                             input t_result hand_want = '0);
        t_result frame_res;
        while (sender_pauses()) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge i_clk);
        while (!rx_if.ready);
        sent_bytes++;
        if (parse_byte(b, frame_res))
            expected_frames.push_back(use_hand ? hand_want : frame_res);
    endtask

    // Body byte biased toward word extremes and sync patterns
    function automatic logic [7:0] pick_body_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            4:       return SYNC_FIRST;
            5:       return SYNC_SECOND;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Full frame with preamble; the check byte is spoiled when asked
    task automatic send_frame(input bit spoil);
        logic [7:0] check_byte;
        logic [7:0] b;
        int         k;
        if ($urandom_range(3) == 0)
            send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        check_byte = SYNC_FIRST ^ SYNC_SECOND;
        for (k = 2; k < FRAME_LEN - 1; k++) begin
            b = (k == 2) ? 8'($urandom_range(255)) : pick_body_byte();
            check_byte ^= b;
            send_byte(b);
        end
        if (spoil)
            check_byte ^= 8'($urandom_range(255, 1));
        send_byte(check_byte);
    endtask

    // ---------------------------------------------------------------------
    // Result receiver and checker
    // ---------------------------------------------------------------------
    task automatic check_field(input string field_name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("frame %0d: %s expected %h, got %h",
                         frames_checked, field_name, want_v, got_v);
        end
    endtask

    function automatic bit receiver_pauses();
        if (frames_checked >= 30 && frames_checked < 45)
            return 1'b0;
        return $urandom_range(99) < IDLE_PERCENT;
    endfunction

    // One long hold-off once the first few frames are through
    always @(posedge i_clk) begin
        if (!hold_done && frames_checked >= 2) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_frames.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("frame %0d: result with none expected", frames_checked);
                end else begin
                    oldest_frame = expected_frames.pop_front();
                    check_field("frame_ok", 32'(oldest_frame.frame_ok),
                                32'(res_if.item.frame_ok));
                    check_field("mode_flags", 32'(oldest_frame.mode_flags),
                                32'(res_if.item.mode_flags));
                    check_field("manual_speed", 32'(oldest_frame.manual_speed),
                                32'(res_if.item.manual_speed));
                    check_field("error_norm", 32'(oldest_frame.error_norm),
                                32'(res_if.item.error_norm));
                    check_field("error_rate", 32'(oldest_frame.error_rate),
                                32'(res_if.item.error_rate));
                    check_field("prop_gain", 32'(oldest_frame.prop_gain),
                                32'(res_if.item.prop_gain));
                    check_field("speed_ceiling", 32'(oldest_frame.speed_ceiling),
                                32'(res_if.item.speed_ceiling));
                    check_field("deriv_time", 32'(oldest_frame.deriv_time),
                                32'(res_if.item.deriv_time));
                    check_field("pot_center_value", 32'(oldest_frame.pot_center_value),
                                32'(res_if.item.pot_center_value));
                    check_field("velocity_gain", 32'(oldest_frame.velocity_gain),
                                32'(res_if.item.velocity_gain));
                    check_field("good_frames", oldest_frame.good_frames,
                                res_if.item.good_frames);
                    check_field("bad_frames", oldest_frame.bad_frames,
                                res_if.item.bad_frames);
                end
                frames_checked <= frames_checked + 1;
            end
            res_if.ready <= (hold_left == 0) && !receiver_pauses();
        end
    end

    // ---------------------------------------------------------------------
    // Directed rows: noise, broken and repeated preamble, all-ones good frame
    // ---------------------------------------------------------------------
    t_row directed_rows [DIRECTED_ROWS] = '{
        '{8'h00, 1'b0}, '{8'hAA, 1'b0}, '{8'h12, 1'b0},
        '{8'hAA, 1'b0}, '{8'hAA, 1'b0}, '{8'h55, 1'b0},
        '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b0},
        '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b0},
        '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b0},
        '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b0},
        '{8'hFF, 1'b0},
        '{8'h00, 1'b1}    // check byte: AA ^ 55 ^ seventeen FF = 00
    };

    initial begin
        int  idx;
        int  pick;
        int  n;
        int  drain_cycles;
        bit  leftover;

        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        sent_bytes = 0;
        leftover = 1'b0;
        clear_parser_model();

        all_ones_frame = '{frame_ok: 1'b1, mode_flags: 2'b11,
                           manual_speed: 16'hFFFF, error_norm: 16'hFFFF,
                           error_rate: 16'hFFFF, prop_gain: 16'hFFFF,
                           speed_ceiling: 16'hFFFF, deriv_time: 16'hFFFF,
                           pot_center_value: 16'hFFFF, velocity_gain: 16'hFFFF,
                           good_frames: 32'd1, bad_frames: 32'd0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (idx = 0; idx < DIRECTED_ROWS; idx++)
            send_byte(directed_rows[idx].rx_byte, directed_rows[idx].hand_checked,
                      all_ones_frame);

        // Mostly whole frames, some noise, broken preambles and cut-off frames
        while (sent_bytes < DIRECTED_ROWS + RANDOM_BYTES) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                send_frame($urandom_range(99) < 30);
            end else if (pick < 88) begin
                n = $urandom_range(4, 1);
                for (idx = 0; idx < n; idx++)
                    send_byte(8'($urandom_range(255)));
            end else if (pick < 95) begin
                send_byte(SYNC_FIRST);
                send_byte(8'($urandom_range(255)));
            end else begin
                send_byte(SYNC_FIRST);
                send_byte(SYNC_SECOND);
                n = $urandom_range(16);
                for (idx = 0; idx < n; idx++)
                    send_byte(pick_body_byte());
            end
        end
        rx_if.valid <= 1'b0;

        drain_cycles = 0;
        while (expected_frames.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (expected_frames.size() != 0) begin
            leftover = 1'b1;
            $display("%0d expected frames never arrived", expected_frames.size());
        end

        $display("sent %0d bytes; %0d frames checked, %0d passed XOR and %0d failed",
                 sent_bytes, frames_checked, good_total, bad_total);
        $display("%0d field mismatches, long receiver hold-off %s",
                 mismatch_count, hold_done ? "applied" : "not reached");

        if (mismatch_count == 0 && !leftover)
            $display("sync_framed_xor_packet_parser_unit_tb: clean");
        else
            $display("sync_framed_xor_packet_parser_unit_tb: errors");
        $finish;
    end

endmodule
